[hdl/sng_pkg.sv]
// Sidechain noise gate package: widths, register map, config and command types.
// No dependencies; imported by every module of the gate.
package sng_pkg;

    localparam int SAMPLE_W = 24;                // Q1.23 samples
    localparam int COEF_W   = 24;                // Q0.24 coefficients
    localparam int THR_W    = SAMPLE_W - 1;      // threshold magnitude
    localparam int MA_W     = SAMPLE_W + 2;      // signed difference operand
    localparam int MB_W     = COEF_W + 1;        // coefficient operand, signed view
    localparam int P_W      = MA_W + MB_W;       // product
    localparam int STEP_W   = P_W - COEF_W;      // product after the Q0.24 shift

    localparam int APB_DW   = 32;
    localparam int REG_N    = 8;
    localparam int REG_IW   = $clog2(REG_N);
    localparam int ADDR_W   = REG_IW + 2;

    localparam logic [REG_IW-1:0] REG_HP_COEF   = REG_IW'(0);
    localparam logic [REG_IW-1:0] REG_LP_COEF   = REG_IW'(1);
    localparam logic [REG_IW-1:0] REG_ATK_COEF  = REG_IW'(2);
    localparam logic [REG_IW-1:0] REG_REL_COEF  = REG_IW'(3);
    localparam logic [REG_IW-1:0] REG_OPEN_COEF = REG_IW'(4);
    localparam logic [REG_IW-1:0] REG_CLOSE_COEF = REG_IW'(5);
    localparam logic [REG_IW-1:0] REG_OPEN_THR  = REG_IW'(6);
    localparam logic [REG_IW-1:0] REG_CLOSE_THR = REG_IW'(7);

    typedef struct packed {
        logic [COEF_W-1:0] hp_coef;
        logic [COEF_W-1:0] lp_coef;
        logic [COEF_W-1:0] atk_coef;
        logic [COEF_W-1:0] rel_coef;
        logic [COEF_W-1:0] open_coef;
        logic [COEF_W-1:0] close_coef;
        logic [THR_W-1:0]  open_thr;
        logic [THR_W-1:0]  close_thr;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        hp_coef:    COEF_W'(216800),
        lp_coef:    COEF_W'(4953000),
        atk_coef:   COEF_W'(231400),
        rel_coef:   COEF_W'(1589),
        open_coef:  COEF_W'(345900),
        close_coef: COEF_W'(1942),
        open_thr:   THR_W'(8389),
        close_thr:  THR_W'(3775)
    };

    // which filter the shared multiplier serves
    typedef enum logic [2:0] {
        SEL_HP  = 3'd0,
        SEL_SC  = 3'd1,
        SEL_ENV = 3'd2,
        SEL_GN  = 3'd3,
        SEL_OUT = 3'd4
    } t_sel;

    typedef struct packed {
        logic load;     // latch input word
        logic mul;      // register product
        logic upd;      // fold product into selected state
        t_sel sel;
        logic out_wr;   // load output register
    } t_cmd;

endpackage

[hdl/sng_regs.sv]
// Sidechain noise gate configuration registers behind an APB-style port.
// Depends on sng_pkg.
module sng_regs
    import sng_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg              r_cfg;
    logic [REG_IW-1:0] w_idx;
    logic              w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_HP_COEF:    r_cfg.hp_coef    <= pwdata[COEF_W-1:0];
                REG_LP_COEF:    r_cfg.lp_coef    <= pwdata[COEF_W-1:0];
                REG_ATK_COEF:   r_cfg.atk_coef   <= pwdata[COEF_W-1:0];
                REG_REL_COEF:   r_cfg.rel_coef   <= pwdata[COEF_W-1:0];
                REG_OPEN_COEF:  r_cfg.open_coef  <= pwdata[COEF_W-1:0];
                REG_CLOSE_COEF: r_cfg.close_coef <= pwdata[COEF_W-1:0];
                REG_OPEN_THR:   r_cfg.open_thr   <= pwdata[THR_W-1:0];
                REG_CLOSE_THR:  r_cfg.close_thr  <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HP_COEF:    prdata = APB_DW'(r_cfg.hp_coef);
            REG_LP_COEF:    prdata = APB_DW'(r_cfg.lp_coef);
            REG_ATK_COEF:   prdata = APB_DW'(r_cfg.atk_coef);
            REG_REL_COEF:   prdata = APB_DW'(r_cfg.rel_coef);
            REG_OPEN_COEF:  prdata = APB_DW'(r_cfg.open_coef);
            REG_CLOSE_COEF: prdata = APB_DW'(r_cfg.close_coef);
            REG_OPEN_THR:   prdata = APB_DW'(r_cfg.open_thr);
            REG_CLOSE_THR:  prdata = APB_DW'(r_cfg.close_thr);
            default:        prdata = '0;
        endcase
    end

endmodule

[hdl/sng_ctrl.sv]
// Sidechain noise gate sequencer: walks the filters over the shared multiplier.
// Depends on sng_pkg; drives sng_dp through t_cmd.
module sng_ctrl
    import sng_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_gate_on,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_HP_MUL  = 11'b000_0000_0010,
        S_HP_UPD  = 11'b000_0000_0100,
        S_SC_MUL  = 11'b000_0000_1000,
        S_SC_UPD  = 11'b000_0001_0000,
        S_ENV_MUL = 11'b000_0010_0000,
        S_ENV_UPD = 11'b000_0100_0000,
        S_GN_MUL  = 11'b000_1000_0000,
        S_GN_UPD  = 11'b001_0000_0000,
        S_OUT_MUL = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.sel    = SEL_HP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_gate_on ? S_HP_MUL : S_DONE;
                end
            end
            S_HP_MUL:  begin o_cmd.mul = 1'b1; o_cmd.sel = SEL_HP;  n_state = S_HP_UPD;  end
            S_HP_UPD:  begin o_cmd.upd = 1'b1; o_cmd.sel = SEL_HP;  n_state = S_SC_MUL;  end
            S_SC_MUL:  begin o_cmd.mul = 1'b1; o_cmd.sel = SEL_SC;  n_state = S_SC_UPD;  end
            S_SC_UPD:  begin o_cmd.upd = 1'b1; o_cmd.sel = SEL_SC;  n_state = S_ENV_MUL; end
            S_ENV_MUL: begin o_cmd.mul = 1'b1; o_cmd.sel = SEL_ENV; n_state = S_ENV_UPD; end
            S_ENV_UPD: begin o_cmd.upd = 1'b1; o_cmd.sel = SEL_ENV; n_state = S_GN_MUL;  end
            S_GN_MUL:  begin o_cmd.mul = 1'b1; o_cmd.sel = SEL_GN;  n_state = S_GN_UPD;  end
            S_GN_UPD:  begin o_cmd.upd = 1'b1; o_cmd.sel = SEL_GN;  n_state = S_OUT_MUL; end
            S_OUT_MUL: begin o_cmd.mul = 1'b1; o_cmd.sel = SEL_OUT; n_state = S_DONE;    end
            S_DONE: begin
                o_cmd.sel = SEL_OUT;
                if (w_out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_wr) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hdl/sng_dp.sv]
// Sidechain noise gate datapath: filter state, one shared multiplier, output register.
// Depends on sng_pkg; steered by t_cmd from sng_ctrl.
module sng_dp
    import sng_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  t_cmd                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_raw_sample,
    input  logic signed [SAMPLE_W-1:0] i_amp_sample,
    input  logic                       i_gate_on,
    output logic signed [SAMPLE_W-1:0] o_gated_sample,
    output logic                       o_gate_open,
    output logic [COEF_W-1:0]          o_gate_gain
);

    // input word
    logic signed [SAMPLE_W-1:0] r_x, r_amp;
    logic                       r_on;
    // filter state
    logic signed [SAMPLE_W-1:0] r_hp_lp;
    logic signed [SAMPLE_W:0]   r_sc;
    logic [SAMPLE_W-1:0]        r_env;
    logic                       r_open;
    logic [COEF_W-1:0]          r_gain;
    // product and output word
    logic signed [P_W-1:0]      r_prod;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                       r_open_o;
    logic [COEF_W-1:0]          r_gain_o;

    logic signed [SAMPLE_W:0]   w_hp;
    logic signed [SAMPLE_W:0]   w_sc_neg;
    logic [SAMPLE_W-1:0]        w_mag;
    logic signed [MA_W-1:0]     w_a;
    logic [COEF_W-1:0]          w_coef;
    logic signed [MB_W-1:0]     w_b;
    logic signed [P_W-1:0]      w_prod;
    logic signed [STEP_W-1:0]   w_step;
    logic signed [MA_W-1:0]     w_base, w_sum;
    logic [SAMPLE_W-1:0]        w_env_n;
    logic                       w_sat_hi, w_sat_lo;
    logic signed [SAMPLE_W-1:0] w_y;

    assign w_hp     = (SAMPLE_W+1)'(r_x) - (SAMPLE_W+1)'(r_hp_lp);
    assign w_sc_neg = -r_sc;
    assign w_mag    = r_sc[SAMPLE_W] ? w_sc_neg[SAMPLE_W-1:0] : r_sc[SAMPLE_W-1:0];

    // multiplier operands
    always_comb begin
        case (i_cmd.sel)
            SEL_HP: begin
                w_a    = MA_W'(r_x) - MA_W'(r_hp_lp);
                w_coef = i_cfg.hp_coef;
            end
            SEL_SC: begin
                w_a    = MA_W'(w_hp) - MA_W'(r_sc);
                w_coef = i_cfg.lp_coef;
            end
            SEL_ENV: begin
                w_a    = $signed(MA_W'(w_mag)) - $signed(MA_W'(r_env));
                w_coef = (w_mag > r_env) ? i_cfg.atk_coef : i_cfg.rel_coef;
            end
            SEL_GN: begin
                // target is exactly one while open, so the rise rate always applies then
                w_a    = (r_open ? $signed(MA_W'(1) <<< COEF_W) : '0)
                         - $signed(MA_W'(r_gain));
                w_coef = r_open ? i_cfg.open_coef : i_cfg.close_coef;
            end
            SEL_OUT: begin
                w_a    = MA_W'(r_amp);
                w_coef = r_gain;
            end
            default: begin
                w_a    = '0;
                w_coef = '0;
            end
        endcase
    end

    assign w_b    = $signed({1'b0, w_coef});
    assign w_prod = w_a * w_b;
    // high bits of the product: floor division by 2^COEF_W
    assign w_step = r_prod[P_W-1:COEF_W];

    always_comb begin
        case (i_cmd.sel)
            SEL_HP:  w_base = MA_W'(r_hp_lp);
            SEL_SC:  w_base = MA_W'(r_sc);
            SEL_ENV: w_base = $signed(MA_W'(r_env));
            SEL_GN:  w_base = $signed(MA_W'(r_gain));
            default: w_base = '0;
        endcase
    end

    assign w_sum   = w_base + w_step[MA_W-1:0];
    assign w_env_n = w_sum[SAMPLE_W-1:0];

    // saturate the scaled amp sample; a bypassed word passes the amp sample unchanged
    assign w_sat_hi = !w_step[STEP_W-1] && (|w_step[STEP_W-2:SAMPLE_W-1]);
    assign w_sat_lo = w_step[STEP_W-1] && !(&w_step[STEP_W-2:SAMPLE_W-1]);
    always_comb begin
        if (!r_on) begin
            w_y = r_amp;
        end else if (w_sat_hi) begin
            w_y = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (w_sat_lo) begin
            w_y = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            w_y = w_step[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp_lp <= '0;
            r_sc    <= '0;
            r_env   <= '0;
            r_open  <= 1'b0;
            r_gain  <= '0;
        end else if (i_cmd.upd) begin
            case (i_cmd.sel)
                SEL_HP: r_hp_lp <= w_sum[SAMPLE_W-1:0];
                SEL_SC: r_sc    <= w_sum[SAMPLE_W:0];
                SEL_ENV: begin
                    r_env <= w_env_n;
                    if (!r_open) begin
                        r_open <= (w_env_n >= SAMPLE_W'(i_cfg.open_thr));
                    end else if (w_env_n < SAMPLE_W'(i_cfg.close_thr)) begin
                        r_open <= 1'b0;
                    end
                end
                SEL_GN: r_gain <= w_sum[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_raw_sample;
            r_amp <= i_amp_sample;
            r_on  <= i_gate_on;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.out_wr) begin
            r_y      <= w_y;
            r_open_o <= r_open;
            r_gain_o <= r_gain;
        end
    end

    assign o_gated_sample = r_y;
    assign o_gate_open    = r_open_o;
    assign o_gate_gain    = r_gain_o;

endmodule

[hdl/sidechain_noise_gate_unit.sv]
// Sidechain noise gate, top level: config registers, sequencer and datapath.
// Depends on sng_pkg, sng_regs, sng_ctrl, sng_dp.
//
// Use:
//  - Input channel (i_in_valid / o_in_stall) takes one word per sample: raw
//    sample for the sidechain, amp sample to be gated, gate_on.
//  - Output channel (o_out_valid / i_out_stall) gives one word per input word:
//    gated sample, hysteresis state and smoothed gain after that sample.
//  - With gate_on high the word runs high-pass, sidechain low-pass, envelope
//    with hysteresis, gain glide and the final scaling on one shared 26x25
//    multiplier: each filter a multiply step and an update step, the scaling a
//    multiply step and then the write of the output register.
//  - With gate_on low the amp sample passes through and the filter state holds.
//  - One word is worked at a time; o_in_stall is high while the sequencer is
//    busy. A finished word sits in the output register, so the next input word
//    is taken while the receiver still stalls; if the old word is still held
//    when the new one completes, the sequencer waits in its last step.
//  - Synchronous active-low reset clears the filter state, closes the gate,
//    empties the output register and loads the register defaults.
//  - Registers sit at byte address 4*i, to be written by the user only while idle (unenforced).
module sidechain_noise_gate_unit
    import sng_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready,
    // input words
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_raw_sample,
    input  logic signed [SAMPLE_W-1:0] i_amp_sample,
    input  logic                       i_gate_on,
    // result words
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_gated_sample,
    output logic                       o_gate_open,
    output logic [COEF_W-1:0]          o_gate_gain
);

    t_cfg w_cfg;
    t_cmd w_cmd;

    sng_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: one-hot walk over the filter steps
    sng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_gate_on   (i_gate_on),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // datapath: state registers, shared multiplier, output register
    sng_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .i_raw_sample   (i_raw_sample),
        .i_amp_sample   (i_amp_sample),
        .i_gate_on      (i_gate_on),
        .o_gated_sample (o_gated_sample),
        .o_gate_open    (o_gate_open),
        .o_gate_gain    (o_gate_gain)
    );

endmodule

[hdl/sng_chk.sv]
// Port-level checks for the sidechain noise gate, bound to the top level.
// Depends on sng_pkg and sidechain_noise_gate_unit.
module sng_chk
    import sng_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic signed [SAMPLE_W-1:0] i_amp_sample,
    input logic                       i_gate_on,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_gated_sample,
    input logic                       o_gate_open,
    input logic [COEF_W-1:0]          o_gate_gain
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // one word in flight: busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in flight");

    // a bypassed word comes straight through next to no work
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_gate_on && !o_out_valid) |=> ##1
        (o_out_valid && o_gated_sample == $past(i_amp_sample, 2)))
        else $error("bypassed word not passed through");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_gated_sample) && $stable(o_gate_open)
         && $stable(o_gate_gain)))
        else $error("stalled result word changed");

endmodule

bind sidechain_noise_gate_unit sng_chk u_chk (.*);

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for sidechain_noise_gate_unit: bit-true gate predictor, stimulus
// tasks and a result checker. Depends on sng_pkg and the gate RTL only.
module testbench;
    import sng_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no word, no register write

    typedef struct {
        logic signed [SAMPLE_W-1:0] gated;
        logic                       open;
        logic [COEF_W-1:0]          gain;
    } t_gate_word;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [APB_DW-1:0]          pwdata = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_raw_sample = '0;
    logic signed [SAMPLE_W-1:0] i_amp_sample = '0;
    logic                       i_gate_on = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b1;
    logic signed [SAMPLE_W-1:0] o_gated_sample;
    logic                       o_gate_open;
    logic [COEF_W-1:0]          o_gate_gain;

    // predictor copy of registers and filter state
    t_cfg   gate_cfg = CFG_RESET;
    longint hp_lp_acc = 0;
    longint sc_acc = 0;
    longint env_level = 0;
    bit     gate_is_open = 1'b0;
    longint gain_level = 0;

    t_gate_word due_words[$];
    t_gate_word want;
    int         mismatch_count = 0;
    int         words_checked = 0;
    int         idle_cycles = 0;
    int         in_idle_pct = 0;
    int         out_stall_pct = 0;
    int         hold_request = 0;
    int         hold_left = 0;

    sidechain_noise_gate_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_sample   (i_raw_sample),
        .i_amp_sample   (i_amp_sample),
        .i_gate_on      (i_gate_on),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_gated_sample (o_gated_sample),
        .o_gate_open    (o_gate_open),
        .o_gate_gain    (o_gate_gain)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one-pole glide, floor by arithmetic shift
    function automatic longint glide(longint s, longint t, longint c);
        return s + (((t - s) * c) >>> COEF_W);
    endfunction

    // advance the gate by one accepted word, return the word it must emit
    function automatic t_gate_word gate_step(logic signed [SAMPLE_W-1:0] raw,
                                             logic signed [SAMPLE_W-1:0] amp,
                                             logic on);
        t_gate_word r;
        longint x, a, hp, mag, tgt, rate, prod;
        x = raw;
        a = amp;
        r.gated = amp;
        if (on) begin
            hp_lp_acc = glide(hp_lp_acc, x, gate_cfg.hp_coef);
            hp = x - hp_lp_acc;
            sc_acc = glide(sc_acc, hp, gate_cfg.lp_coef);
            mag = (sc_acc < 0) ? -sc_acc : sc_acc;
            rate = (mag > env_level) ? gate_cfg.atk_coef : gate_cfg.rel_coef;
            env_level = glide(env_level, mag, rate);
            // hysteresis: thresholds taken as they stand, in either order
            if (!gate_is_open) begin
                if (env_level >= longint'(gate_cfg.open_thr)) gate_is_open = 1'b1;
            end else if (env_level < longint'(gate_cfg.close_thr)) begin
                gate_is_open = 1'b0;
            end
            tgt = gate_is_open ? (longint'(1) << COEF_W) : 0;
            rate = (tgt > gain_level) ? gate_cfg.open_coef : gate_cfg.close_coef;
            gain_level = glide(gain_level, tgt, rate);
            prod = (a * gain_level) >>> COEF_W;
            if (prod > S_MAX) prod = S_MAX;
            if (prod < S_MIN) prod = S_MIN;
            r.gated = prod[SAMPLE_W-1:0];
        end
        r.open = gate_is_open;
        r.gain = gain_level[COEF_W-1:0];
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] pick_rate();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return r[COEF_W-1:0] >> $urandom_range(8);
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return r[THR_W-1:0] >> $urandom_range(3, 16);
        endcase
    endfunction

    function automatic t_cfg pick_config();
        t_cfg c;
        c.hp_coef    = pick_rate();
        c.lp_coef    = pick_rate();
        c.atk_coef   = pick_rate();
        c.rel_coef   = pick_rate();
        c.open_coef  = pick_rate();
        c.close_coef = pick_rate();
        c.open_thr   = pick_threshold();
        c.close_thr  = pick_threshold();
        return c;
    endfunction

    // all tasks below start and end just after a falling edge

    task automatic write_reg(logic [REG_IW-1:0] idx, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // bits above the register width are dropped
        case (idx)
            REG_HP_COEF:    gate_cfg.hp_coef    = data[COEF_W-1:0];
            REG_LP_COEF:    gate_cfg.lp_coef    = data[COEF_W-1:0];
            REG_ATK_COEF:   gate_cfg.atk_coef   = data[COEF_W-1:0];
            REG_REL_COEF:   gate_cfg.rel_coef   = data[COEF_W-1:0];
            REG_OPEN_COEF:  gate_cfg.open_coef  = data[COEF_W-1:0];
            REG_CLOSE_COEF: gate_cfg.close_coef = data[COEF_W-1:0];
            REG_OPEN_THR:   gate_cfg.open_thr   = data[THR_W-1:0];
            REG_CLOSE_THR:  gate_cfg.close_thr  = data[THR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // whole register set, with junk in the unused upper bits
    task automatic load_config(t_cfg c);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_HP_COEF,    {junk[31:24], c.hp_coef});
        write_reg(REG_LP_COEF,    {junk[30:23], c.lp_coef});
        write_reg(REG_ATK_COEF,   {junk[29:22], c.atk_coef});
        write_reg(REG_REL_COEF,   {junk[28:21], c.rel_coef});
        write_reg(REG_OPEN_COEF,  {junk[27:20], c.open_coef});
        write_reg(REG_CLOSE_COEF, {junk[26:19], c.close_coef});
        write_reg(REG_OPEN_THR,   {junk[8:0],   c.open_thr});
        write_reg(REG_CLOSE_THR,  {junk[17:9],  c.close_thr});
    endtask

    // valid is left high on return so back-to-back words need no re-drive
    task automatic send_word(logic signed [SAMPLE_W-1:0] raw,
                             logic signed [SAMPLE_W-1:0] amp, logic on);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_sample <= raw;
        i_amp_sample <= amp;
        i_gate_on    <= on;
        do @(posedge i_clk); while (o_in_stall);
        due_words.push_back(gate_step(raw, amp, on));
        @(negedge i_clk);
    endtask

    // drop valid and let every expected word come back; block is then idle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // bursts of loud signal and quiet stretches so the gate opens and closes,
    // with about one word in ten fully random
    task automatic send_bursts(int n);
        int sent, len, shift;
        logic loud;
        logic [31:0] r, q;
        sent = 0;
        while (sent < n) begin
            len   = $urandom_range(3, 80);
            loud  = 1'($urandom_range(1));
            shift = loud ? $urandom_range(0, 4) : $urandom_range(10, 22);
            for (int k = 0; k < len && sent < n; k++) begin
                r = $urandom;
                q = $urandom;
                if ($urandom_range(9) == 0)
                    send_word(r[SAMPLE_W-1:0], q[SAMPLE_W-1:0], 1'($urandom_range(1)));
                else
                    send_word($signed(r[SAMPLE_W-1:0]) >>> shift, q[SAMPLE_W-1:0],
                              $urandom_range(19) != 0);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        t_cfg c;
        // reset settings: zero word, bypass at both extremes, then hard swings
        send_word('0, '0, 1'b1);
        send_word(S_MAX, S_MAX, 1'b0);
        send_word(S_MIN, S_MIN, 1'b0);
        send_word(S_MAX, S_MAX, 1'b1);
        send_word(S_MIN, S_MIN, 1'b1);
        repeat (3) begin
            send_word(S_MAX, -24'sd1, 1'b1);
            send_word(S_MIN, 24'sd1, 1'b1);
        end
        wait_drained();
        // fastest rates, zero thresholds: gate opens at once, gain heads for one
        c = CFG_RESET;
        c.hp_coef = '1;  c.lp_coef = '1;   c.atk_coef = '1;
        c.rel_coef = '1; c.open_coef = '1; c.close_coef = '1;
        c.open_thr = '0; c.close_thr = '0;
        load_config(c);
        send_word(S_MAX, S_MAX, 1'b1);
        send_word(S_MIN, S_MIN, 1'b1);
        send_word('0, -24'sd1, 1'b1);
        send_word(S_MIN, S_MAX, 1'b0);   // bypass while open: state must hold
        send_word(S_MAX, 24'sd1, 1'b1);
        send_word('0, S_MIN, 1'b1);
        wait_drained();
        // thresholds inverted: opens when closed, closes again when open
        c.open_thr = '0;
        c.close_thr = '1;
        load_config(c);
        repeat (2) begin
            send_word(S_MAX, S_MAX, 1'b1);
            send_word(S_MIN, S_MIN, 1'b1);
        end
        wait_drained();
        // frozen filters, unreachable open level
        c.hp_coef = '0;  c.lp_coef = '0;   c.atk_coef = '0;
        c.rel_coef = '0; c.open_coef = '0; c.close_coef = '0;
        c.open_thr = '1; c.close_thr = '1;
        load_config(c);
        send_word(S_MAX, S_MAX, 1'b1);
        send_word(S_MIN, S_MIN, 1'b1);
        send_word(S_MAX, S_MIN, 1'b0);
        wait_drained();
    endtask

    task automatic test_config_sweep();
        repeat (4) begin
            load_config(pick_config());
            send_bursts(40);
            wait_drained();
        end
    endtask

    task automatic test_flow(int sender_idle, int receiver_stall, int n);
        in_idle_pct   = sender_idle;
        out_stall_pct = receiver_stall;
        load_config(pick_config());
        send_bursts(n);
        wait_drained();
        in_idle_pct   = 0;
        out_stall_pct = 0;
    endtask

    // receiver holds off long enough for the gate to back up into its input
    task automatic test_backpressure();
        load_config(pick_config());
        hold_request = 400;
        send_bursts(12);
        wait_drained();            // sender stays quiet until all words are back
        in_idle_pct   = 50;
        out_stall_pct = 50;
        send_bursts(40);
        wait_drained();
        in_idle_pct   = 0;
        out_stall_pct = 0;
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_checked++;
            if (due_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("word %0d unexpected: gated %0d open %0b gain %0d",
                             words_checked, o_gated_sample, o_gate_open, o_gate_gain);
            end else begin
                want = due_words.pop_front();
                if (o_gated_sample !== want.gated || o_gate_open !== want.open ||
                    o_gate_gain !== want.gain) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word %0d: gated %0d/%0d open %0b/%0b gain %0d/%0d (exp/got)",
                                 words_checked, want.gated, o_gated_sample,
                                 want.open, o_gate_open, want.gain, o_gate_gain);
                end
            end
        end
    end

    // watchdog: any word moved or register written counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pwrite && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("sidechain_noise_gate_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_sweep();
        test_flow(0, 0, 280);
        test_flow(79, 0, 280);
        test_flow(0, 79, 280);
        test_flow(23, 23, 280);
        test_backpressure();
        wait_drained();
        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0 && due_words.size() == 0)
            $display("sidechain_noise_gate_unit regression: pass");
        else
            $display("sidechain_noise_gate_unit regression: fail");
        $finish;
    end

endmodule

[sim.f]
hdl/sng_pkg.sv
hdl/sng_regs.sv
hdl/sng_ctrl.sv
hdl/sng_dp.sv
hdl/sidechain_noise_gate_unit.sv
hdl/sng_chk.sv
sim/testbench.sv
